// ----- rtl/nms_pkg.sv -----
// Types, register indexes and state records shared by the navigation mode sequencer.
package nms_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;
  localparam int unsigned ThreshWidth   = 15;
  localparam int unsigned TimeoutWidth  = 16;
  localparam int unsigned VelWidth      = 16;
  localparam int unsigned MagWidth      = VelWidth + 1;
  localparam int unsigned StampWidth    = 32;

  localparam logic [CfgIndexWidth-1:0] REG_STUCK_ENABLE        = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_SPIN_STOP_SPEED_MAX = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_TRACK_STOP_RATE_MAX = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_IDLE_STOP_SPEED_MAX = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_IDLE_STOP_RATE_MAX  = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_STOP_TIMEOUT_MS     = 3'd5;
  localparam logic [CfgIndexWidth-1:0] REG_REVERSE_TIME_MS     = 3'd6;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_TRACK    = 3'd1,
    MODE_SPIN     = 3'd2,
    MODE_STOP     = 3'd3,
    MODE_HOLD     = 3'd4,
    MODE_REVERSE  = 3'd5,
    MODE_RECOVERY = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    DEST_IDLE  = 2'd0,
    DEST_TRACK = 2'd1,
    DEST_SPIN  = 2'd2,
    DEST_HOLD  = 2'd3
  } dest_e;

  typedef struct packed {
    logic                    stuck_enable;
    logic [ThreshWidth-1:0]  spin_stop_speed_max;
    logic [ThreshWidth-1:0]  track_stop_rate_max;
    logic [ThreshWidth-1:0]  idle_stop_speed_max;
    logic [ThreshWidth-1:0]  idle_stop_rate_max;
    logic [TimeoutWidth-1:0] stop_timeout_ms;
    logic [TimeoutWidth-1:0] reverse_time_ms;
  } cfg_t;

  typedef struct packed {
    logic                       path_present;
    logic                       path_fresh;
    logic                       spin_wanted;
    logic                       spin_urgent;
    logic                       goal_fixed;
    logic                       stuck_seen;
    logic                       hazard_seen;
    logic                       goal_reached;
    logic                       recovery_safe;
    logic signed [VelWidth-1:0] linear_speed;
    logic signed [VelWidth-1:0] turn_rate;
    logic [StampWidth-1:0]      time_ms;
  } item_t;

  typedef struct packed {
    mode_e                 mode;
    dest_e                 stop_target;
    logic [StampWidth-1:0] stop_begin_ms;
    logic [StampWidth-1:0] reverse_begin_ms;
  } state_t;

endpackage

// ----- rtl/nms_step.sv -----
// Next-state and result logic for one planner tick of the mode sequencer.
module nms_step (
  input  nms_pkg::state_t st_i,
  input  nms_pkg::cfg_t   cfg_i,
  input  nms_pkg::item_t  item_i,
  output nms_pkg::state_t st_o,
  output logic            consume_o
);

  logic                                 stuck;
  logic                                 hazard;
  logic [nms_pkg::MagWidth-1:0]         speed_ext;
  logic [nms_pkg::MagWidth-1:0]         rate_ext;
  logic [nms_pkg::MagWidth-1:0]         speed_mag;
  logic [nms_pkg::MagWidth-1:0]         rate_mag;
  logic [nms_pkg::StampWidth-1:0]       stop_elapsed;
  logic [nms_pkg::StampWidth-1:0]       rev_elapsed;
  logic                                 stop_expired;
  logic                                 rev_expired;
  logic                                 stop_done;
  logic                                 spin_keep;
  nms_pkg::dest_e                       idle_or_hold;

  assign stuck  = item_i.stuck_seen & cfg_i.stuck_enable;
  assign hazard = item_i.hazard_seen & cfg_i.stuck_enable;

  // Sign-extend to 17 bits so that the most negative value has a magnitude.
  assign speed_ext = {item_i.linear_speed[nms_pkg::VelWidth-1], item_i.linear_speed};
  assign rate_ext  = {item_i.turn_rate[nms_pkg::VelWidth-1], item_i.turn_rate};
  assign speed_mag = speed_ext[nms_pkg::MagWidth-1] ? (~speed_ext + 1'b1) : speed_ext;
  assign rate_mag  = rate_ext[nms_pkg::MagWidth-1] ? (~rate_ext + 1'b1) : rate_ext;

  assign stop_elapsed = item_i.time_ms - st_i.stop_begin_ms;
  assign rev_elapsed  = item_i.time_ms - st_i.reverse_begin_ms;
  assign stop_expired = stop_elapsed > {16'd0, cfg_i.stop_timeout_ms};
  assign rev_expired  = rev_elapsed > {16'd0, cfg_i.reverse_time_ms};

  always_comb begin
    unique case (st_i.stop_target)
      nms_pkg::DEST_SPIN: begin
        stop_done = speed_mag < {2'b00, cfg_i.spin_stop_speed_max};
      end
      nms_pkg::DEST_TRACK: begin
        stop_done = rate_mag < {2'b00, cfg_i.track_stop_rate_max};
      end
      default: begin
        stop_done = (speed_mag < {2'b00, cfg_i.idle_stop_speed_max}) &&
                    (rate_mag < {2'b00, cfg_i.idle_stop_rate_max});
      end
    endcase
  end

  assign spin_keep    = item_i.spin_wanted &
                        (item_i.spin_urgent | (~item_i.path_present & ~item_i.goal_fixed));
  assign idle_or_hold = item_i.goal_fixed ? nms_pkg::DEST_HOLD : nms_pkg::DEST_IDLE;

  always_comb begin
    logic           go_stop;
    logic           go_rev;
    nms_pkg::dest_e dest;
    go_stop   = 1'b0;
    go_rev    = 1'b0;
    dest      = nms_pkg::DEST_IDLE;
    st_o      = st_i;
    consume_o = 1'b0;
    unique case (st_i.mode)
      nms_pkg::MODE_IDLE: begin
        if (hazard) begin
          consume_o = 1'b1;
          st_o.mode = nms_pkg::MODE_RECOVERY;
        end else if (item_i.path_fresh) begin
          st_o.mode = nms_pkg::MODE_TRACK;
        end else if (item_i.spin_wanted) begin
          st_o.mode = nms_pkg::MODE_SPIN;
        end
      end
      nms_pkg::MODE_TRACK: begin
        if (!item_i.path_present) begin
          go_stop = 1'b1;
          dest    = (item_i.spin_wanted && (item_i.spin_urgent || !item_i.goal_fixed))
                    ? nms_pkg::DEST_SPIN : idle_or_hold;
        end else if (stuck) begin
          go_rev = 1'b1;
        end else if (item_i.spin_wanted && item_i.spin_urgent) begin
          go_stop = 1'b1;
          dest    = nms_pkg::DEST_SPIN;
        end else if (item_i.goal_reached) begin
          go_stop = 1'b1;
          dest    = idle_or_hold;
        end
      end
      nms_pkg::MODE_SPIN: begin
        if (hazard) begin
          consume_o = 1'b1;
          st_o.mode = nms_pkg::MODE_RECOVERY;
        end else if (stuck) begin
          go_rev = 1'b1;
        end else if (!spin_keep) begin
          go_stop = 1'b1;
          dest    = item_i.path_present ? nms_pkg::DEST_TRACK : idle_or_hold;
        end
      end
      nms_pkg::MODE_STOP: begin
        if (stuck) begin
          go_rev = 1'b1;
        end else if (st_i.stop_target != nms_pkg::DEST_TRACK && item_i.path_fresh) begin
          st_o.mode = nms_pkg::MODE_TRACK;
        end else if (stop_done || stop_expired) begin
          unique case (st_i.stop_target)
            nms_pkg::DEST_IDLE: begin
              consume_o = 1'b1;
              st_o.mode = nms_pkg::MODE_IDLE;
            end
            nms_pkg::DEST_HOLD: begin
              consume_o = 1'b1;
              st_o.mode = nms_pkg::MODE_HOLD;
            end
            nms_pkg::DEST_SPIN: begin
              st_o.mode = nms_pkg::MODE_SPIN;
            end
            default: begin
              st_o.mode = nms_pkg::MODE_TRACK;
            end
          endcase
        end
      end
      nms_pkg::MODE_HOLD: begin
        if (stuck) begin
          go_rev = 1'b1;
        end else if (item_i.spin_wanted && item_i.spin_urgent) begin
          go_stop = 1'b1;
          dest    = nms_pkg::DEST_SPIN;
        end else if (item_i.path_fresh) begin
          st_o.mode = nms_pkg::MODE_TRACK;
        end
      end
      nms_pkg::MODE_REVERSE: begin
        if (rev_expired) begin
          consume_o = 1'b1;
          st_o.mode = nms_pkg::MODE_RECOVERY;
        end
      end
      nms_pkg::MODE_RECOVERY: begin
        if (item_i.path_fresh) begin
          st_o.mode = nms_pkg::MODE_TRACK;
        end else if (item_i.recovery_safe) begin
          st_o.mode = nms_pkg::MODE_IDLE;
        end
      end
      default: begin
        st_o.mode = nms_pkg::MODE_IDLE;
      end
    endcase
    if (go_stop) begin
      st_o.mode          = nms_pkg::MODE_STOP;
      st_o.stop_target   = dest;
      st_o.stop_begin_ms = item_i.time_ms;
    end
    if (go_rev) begin
      st_o.mode             = nms_pkg::MODE_REVERSE;
      st_o.reverse_begin_ms = item_i.time_ms;
    end
  end

endmodule

// ----- rtl/navigation_mode_sequencer.sv -----
// Top level of the navigation mode sequencer: tick register, mode state and result register.
//
// Usage: planner ticks enter on the input channel (in_valid_i / in_ready_o) with nine
// status flags, signed linear speed and turn rate, and a millisecond time stamp.
// Each tick gives exactly one result on the output channel (out_valid_o /
// out_ready_i): the mode after that tick and a consume-path flag.
// An accepted tick waits in the tick register and its result is then registered.
// One tick is accepted every cycle while results are taken; the mode update is a
// single compare-and-select pass between the tick register and the result register,
// with the mode state updated as the tick moves into the result register.
// When the receiver stalls, the result register holds; the tick register still
// takes one more tick, then in_ready_o drops until the result is taken.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_wdata_i) take effect at once; the
// user makes them only while no tick is in flight; the block does not enforce this.
// Unknown indexes are ignored. Reset puts the block in idle mode with the idle stop
// destination, clears the start stamps and loads the default thresholds and timeouts.
module navigation_mode_sequencer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [nms_pkg::CfgIndexWidth-1:0]    cfg_index_i,
  input  logic [nms_pkg::CfgDataWidth-1:0]     cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 in_path_present_i,
  input  logic                                 in_path_fresh_i,
  input  logic                                 in_spin_wanted_i,
  input  logic                                 in_spin_urgent_i,
  input  logic                                 in_goal_fixed_i,
  input  logic                                 in_stuck_seen_i,
  input  logic                                 in_hazard_seen_i,
  input  logic                                 in_goal_reached_i,
  input  logic                                 in_recovery_safe_i,
  input  logic signed [nms_pkg::VelWidth-1:0]  in_linear_speed_i,
  input  logic signed [nms_pkg::VelWidth-1:0]  in_turn_rate_i,
  input  logic [nms_pkg::StampWidth-1:0]       in_time_ms_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [2:0]                           out_mode_o,
  output logic                                 out_consume_path_o
);

  nms_pkg::cfg_t   cfg_q;
  nms_pkg::item_t  item_d, item_q;
  logic            item_valid_q;
  nms_pkg::state_t st_q, st_d;
  logic            consume_d;
  logic            advance;
  logic            out_valid_q;
  logic [2:0]      out_mode_q;
  logic            out_consume_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stuck_enable        <= 1'b1;
      cfg_q.spin_stop_speed_max <= 15'd100;
      cfg_q.track_stop_rate_max <= 15'd100;
      cfg_q.idle_stop_speed_max <= 15'd50;
      cfg_q.idle_stop_rate_max  <= 15'd50;
      cfg_q.stop_timeout_ms     <= 16'd2000;
      cfg_q.reverse_time_ms     <= 16'd1000;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        nms_pkg::REG_STUCK_ENABLE:        cfg_q.stuck_enable        <= cfg_wdata_i[0];
        nms_pkg::REG_SPIN_STOP_SPEED_MAX: cfg_q.spin_stop_speed_max <= cfg_wdata_i[14:0];
        nms_pkg::REG_TRACK_STOP_RATE_MAX: cfg_q.track_stop_rate_max <= cfg_wdata_i[14:0];
        nms_pkg::REG_IDLE_STOP_SPEED_MAX: cfg_q.idle_stop_speed_max <= cfg_wdata_i[14:0];
        nms_pkg::REG_IDLE_STOP_RATE_MAX:  cfg_q.idle_stop_rate_max  <= cfg_wdata_i[14:0];
        nms_pkg::REG_STOP_TIMEOUT_MS:     cfg_q.stop_timeout_ms     <= cfg_wdata_i;
        nms_pkg::REG_REVERSE_TIME_MS:     cfg_q.reverse_time_ms     <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // The held tick moves on whenever the result register is free or being emptied.
  assign advance    = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;

  assign item_d = '{
    path_present:  in_path_present_i,
    path_fresh:    in_path_fresh_i,
    spin_wanted:   in_spin_wanted_i,
    spin_urgent:   in_spin_urgent_i,
    goal_fixed:    in_goal_fixed_i,
    stuck_seen:    in_stuck_seen_i,
    hazard_seen:   in_hazard_seen_i,
    goal_reached:  in_goal_reached_i,
    recovery_safe: in_recovery_safe_i,
    linear_speed:  in_linear_speed_i,
    turn_rate:     in_turn_rate_i,
    time_ms:       in_time_ms_i
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

  nms_step u_step (
    .st_i      (st_q),
    .cfg_i     (cfg_q),
    .item_i    (item_q),
    .st_o      (st_d),
    .consume_o (consume_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode             <= nms_pkg::MODE_IDLE;
      st_q.stop_target      <= nms_pkg::DEST_IDLE;
      st_q.stop_begin_ms    <= '0;
      st_q.reverse_begin_ms <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_mode_q    <= st_d.mode;
      out_consume_q <= consume_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_mode_o         = out_mode_q;
  assign out_consume_path_o = out_consume_q;

  // The shown result always carries the mode the state register holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_mode_o == st_q.mode))
    else $error("result mode differs from state mode");

  // The path is consumed only on entry to idle, hold or recovery.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_consume_path_o) |->
      (out_mode_o == nms_pkg::MODE_IDLE || out_mode_o == nms_pkg::MODE_HOLD ||
       out_mode_o == nms_pkg::MODE_RECOVERY))
    else $error("consume flag with a mode that cannot consume");

  // The mode state moves only when a tick passes into the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(st_q))
    else $error("mode state changed without a tick");

endmodule

// ----- bench/navigation_mode_sequencer_tb.sv -----
// Self-checking testbench for the navigation mode sequencer with a mode predictor.
`timescale 1ns / 1ps

module navigation_mode_sequencer_tb;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_PRINTS   = 100;

  localparam logic [nms_pkg::CfgIndexWidth-1:0] REG_UNUSED = 3'd7;

  // Flag bits in the order of the tick record, path_present first.
  localparam logic [8:0] F_NONE    = 9'h000;
  localparam logic [8:0] F_PRESENT = 9'h100;
  localparam logic [8:0] F_FRESH   = 9'h080;
  localparam logic [8:0] F_SPIN    = 9'h040;
  localparam logic [8:0] F_URGENT  = 9'h020;
  localparam logic [8:0] F_FIXED   = 9'h010;
  localparam logic [8:0] F_STUCK   = 9'h008;
  localparam logic [8:0] F_HAZARD  = 9'h004;
  localparam logic [8:0] F_REACHED = 9'h002;
  localparam logic [8:0] F_SAFE    = 9'h001;
  localparam logic [8:0] F_ALL     = 9'h1FF;

  typedef struct packed {
    nms_pkg::mode_e mode;
    logic           consume_path;
  } result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                              cfg_we    = 1'b0;
  logic [nms_pkg::CfgIndexWidth-1:0] cfg_index = '0;
  logic [nms_pkg::CfgDataWidth-1:0]  cfg_wdata = '0;

  logic           in_valid  = 1'b0;
  logic           out_ready = 1'b0;
  nms_pkg::item_t cur_tick  = '0;

  logic       in_ready_o;
  logic       out_valid_o;
  logic [2:0] out_mode_o;
  logic       out_consume_path_o;

  nms_pkg::item_t tick_q[$];
  result_t        mode_expect_q[$];
  result_t        want;

  nms_pkg::cfg_t   cfg_model;
  nms_pkg::state_t nav_model;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  logic        hold_arm       = 1'b0;
  logic        hold_active    = 1'b0;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;
  logic [nms_pkg::StampWidth-1:0] stamp = '0;

  navigation_mode_sequencer uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .in_path_present_i  (cur_tick.path_present),
    .in_path_fresh_i    (cur_tick.path_fresh),
    .in_spin_wanted_i   (cur_tick.spin_wanted),
    .in_spin_urgent_i   (cur_tick.spin_urgent),
    .in_goal_fixed_i    (cur_tick.goal_fixed),
    .in_stuck_seen_i    (cur_tick.stuck_seen),
    .in_hazard_seen_i   (cur_tick.hazard_seen),
    .in_goal_reached_i  (cur_tick.goal_reached),
    .in_recovery_safe_i (cur_tick.recovery_safe),
    .in_linear_speed_i  (cur_tick.linear_speed),
    .in_turn_rate_i     (cur_tick.turn_rate),
    .in_time_ms_i       (cur_tick.time_ms),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .out_mode_o         (out_mode_o),
    .out_consume_path_o (out_consume_path_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic logic [nms_pkg::MagWidth-1:0] vel_mag(
    input logic [nms_pkg::VelWidth-1:0] v);
    // Full-precision magnitude, so the most negative speed stays at 32768.
    return v[nms_pkg::VelWidth-1] ?
           (nms_pkg::MagWidth'(0) - {v[nms_pkg::VelWidth-1], v}) : {1'b0, v};
  endfunction

  function automatic void enter_stop(input nms_pkg::dest_e dest,
                                     input logic [nms_pkg::StampWidth-1:0] now);
    nav_model.stop_target   = dest;
    nav_model.stop_begin_ms = now;
    nav_model.mode          = nms_pkg::MODE_STOP;
  endfunction

  function automatic void enter_reverse(input logic [nms_pkg::StampWidth-1:0] now);
    nav_model.reverse_begin_ms = now;
    nav_model.mode             = nms_pkg::MODE_REVERSE;
  endfunction

  function automatic result_t next_mode_result(input nms_pkg::item_t t);
    logic                           stuck;
    logic                           hazard;
    logic                           keep;
    logic                           done;
    logic                           consume;
    logic [nms_pkg::MagWidth-1:0]   speed_mag;
    logic [nms_pkg::MagWidth-1:0]   rate_mag;
    logic [nms_pkg::StampWidth-1:0] stop_elapsed;
    logic [nms_pkg::StampWidth-1:0] rev_elapsed;
    nms_pkg::dest_e                 rest_dest;
    result_t                        r;
    stuck        = t.stuck_seen & cfg_model.stuck_enable;
    hazard       = t.hazard_seen & cfg_model.stuck_enable;
    speed_mag    = vel_mag(t.linear_speed);
    rate_mag     = vel_mag(t.turn_rate);
    stop_elapsed = t.time_ms - nav_model.stop_begin_ms;
    rev_elapsed  = t.time_ms - nav_model.reverse_begin_ms;
    rest_dest    = t.goal_fixed ? nms_pkg::DEST_HOLD : nms_pkg::DEST_IDLE;
    keep         = t.spin_wanted & (t.spin_urgent | (~t.path_present & ~t.goal_fixed));
    consume      = 1'b0;
    // A zero threshold is never met, since nothing is below it.
    case (nav_model.stop_target)
      nms_pkg::DEST_SPIN:
        done = speed_mag < nms_pkg::MagWidth'(cfg_model.spin_stop_speed_max);
      nms_pkg::DEST_TRACK:
        done = rate_mag < nms_pkg::MagWidth'(cfg_model.track_stop_rate_max);
      default:
        done = (speed_mag < nms_pkg::MagWidth'(cfg_model.idle_stop_speed_max)) &&
               (rate_mag < nms_pkg::MagWidth'(cfg_model.idle_stop_rate_max));
    endcase
    case (nav_model.mode)
      nms_pkg::MODE_IDLE: begin
        if (hazard) begin
          consume        = 1'b1;
          nav_model.mode = nms_pkg::MODE_RECOVERY;
        end else if (t.path_fresh) begin
          nav_model.mode = nms_pkg::MODE_TRACK;
        end else if (t.spin_wanted) begin
          nav_model.mode = nms_pkg::MODE_SPIN;
        end
      end
      nms_pkg::MODE_TRACK: begin
        if (!t.path_present) begin
          if (t.spin_wanted && (t.spin_urgent || !t.goal_fixed)) begin
            enter_stop(nms_pkg::DEST_SPIN, t.time_ms);
          end else begin
            enter_stop(rest_dest, t.time_ms);
          end
        end else if (stuck) begin
          enter_reverse(t.time_ms);
        end else if (t.spin_wanted && t.spin_urgent) begin
          enter_stop(nms_pkg::DEST_SPIN, t.time_ms);
        end else if (t.goal_reached) begin
          enter_stop(rest_dest, t.time_ms);
        end
      end
      nms_pkg::MODE_SPIN: begin
        if (hazard) begin
          consume        = 1'b1;
          nav_model.mode = nms_pkg::MODE_RECOVERY;
        end else if (stuck) begin
          enter_reverse(t.time_ms);
        end else if (!keep) begin
          if (t.path_present) begin
            enter_stop(nms_pkg::DEST_TRACK, t.time_ms);
          end else begin
            enter_stop(rest_dest, t.time_ms);
          end
        end
      end
      nms_pkg::MODE_STOP: begin
        if (stuck) begin
          enter_reverse(t.time_ms);
        end else if (nav_model.stop_target != nms_pkg::DEST_TRACK && t.path_fresh) begin
          nav_model.mode = nms_pkg::MODE_TRACK;
        end else if (done ||
                     stop_elapsed > nms_pkg::StampWidth'(cfg_model.stop_timeout_ms)) begin
          case (nav_model.stop_target)
            nms_pkg::DEST_IDLE: begin
              consume        = 1'b1;
              nav_model.mode = nms_pkg::MODE_IDLE;
            end
            nms_pkg::DEST_HOLD: begin
              consume        = 1'b1;
              nav_model.mode = nms_pkg::MODE_HOLD;
            end
            nms_pkg::DEST_SPIN: nav_model.mode = nms_pkg::MODE_SPIN;
            default:            nav_model.mode = nms_pkg::MODE_TRACK;
          endcase
        end
      end
      nms_pkg::MODE_HOLD: begin
        if (stuck) begin
          enter_reverse(t.time_ms);
        end else if (t.spin_wanted && t.spin_urgent) begin
          enter_stop(nms_pkg::DEST_SPIN, t.time_ms);
        end else if (t.path_fresh) begin
          nav_model.mode = nms_pkg::MODE_TRACK;
        end
      end
      nms_pkg::MODE_REVERSE: begin
        if (rev_elapsed > nms_pkg::StampWidth'(cfg_model.reverse_time_ms)) begin
          consume        = 1'b1;
          nav_model.mode = nms_pkg::MODE_RECOVERY;
        end
      end
      nms_pkg::MODE_RECOVERY: begin
        if (t.path_fresh) begin
          nav_model.mode = nms_pkg::MODE_TRACK;
        end else if (t.recovery_safe) begin
          nav_model.mode = nms_pkg::MODE_IDLE;
        end
      end
      default: nav_model.mode = nms_pkg::MODE_IDLE;
    endcase
    r.mode         = nav_model.mode;
    r.consume_path = consume;
    return r;
  endfunction

  // ---------------------------------------------------------------- driver and monitor

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        mode_expect_q.push_back(next_mode_result(cur_tick));
      end
      if (!in_valid || in_ready_o) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          cur_tick <= tick_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTS) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
    error_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (mode_expect_q.size() == 0) begin
          report_mismatch($sformatf("result with no tick pending, mode %0d", out_mode_o));
        end else begin
          want = mode_expect_q.pop_front();
          if (out_mode_o !== want.mode) begin
            report_mismatch($sformatf("mode %0d, expected %0d", out_mode_o, want.mode));
          end
          if (out_consume_path_o !== want.consume_path) begin
            report_mismatch($sformatf("consume_path %0b, expected %0b",
                                      out_consume_path_o, want.consume_path));
          end
        end
      end
      out_ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // The receiver backs off for a long stretch so the block fills and stalls its input.
  initial begin
    wait (hold_arm);
    @(posedge clk_i);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_active <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic chance(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic [nms_pkg::VelWidth-1:0] random_velocity();
    logic [nms_pkg::VelWidth-1:0] v;
    case ($urandom_range(3))
      0:       v = nms_pkg::VelWidth'($urandom_range(0, 120));
      1:       v = nms_pkg::VelWidth'($urandom_range(0, 600));
      2:       v = nms_pkg::VelWidth'($urandom_range(0, 5000));
      default: v = nms_pkg::VelWidth'($urandom);
    endcase
    if (chance(50)) v = -v;
    return v;
  endfunction

  // Mostly plausible ticks with advancing stamps; the rest is raw noise.
  function automatic nms_pkg::item_t random_tick();
    logic [8:0]                     flags;
    logic [nms_pkg::VelWidth-1:0]   speed;
    logic [nms_pkg::VelWidth-1:0]   rate;
    logic [nms_pkg::StampWidth-1:0] t_ms;
    if (chance(12)) begin
      flags = 9'($urandom);
      speed = nms_pkg::VelWidth'($urandom);
      rate  = nms_pkg::VelWidth'($urandom);
      t_ms  = $urandom;
    end else begin
      stamp = stamp + $urandom_range(0, 300);
      if (chance(2)) stamp = stamp + $urandom_range(0, 70000);
      flags = {chance(75), chance(20), chance(30), chance(35), chance(30),
               chance(6), chance(6), chance(15), chance(30)};
      speed = random_velocity();
      rate  = random_velocity();
      t_ms  = stamp;
    end
    return nms_pkg::item_t'({flags, speed, rate, t_ms});
  endfunction

  task automatic push_tick(input logic [8:0] flags,
                           input logic [nms_pkg::VelWidth-1:0] speed,
                           input logic [nms_pkg::VelWidth-1:0] rate,
                           input logic [nms_pkg::StampWidth-1:0] t_ms);
    tick_q.push_back(nms_pkg::item_t'({flags, speed, rate, t_ms}));
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid || mode_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [nms_pkg::CfgIndexWidth-1:0] idx,
                           input logic [nms_pkg::CfgDataWidth-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      nms_pkg::REG_STUCK_ENABLE:
        cfg_model.stuck_enable = data[0];
      nms_pkg::REG_SPIN_STOP_SPEED_MAX:
        cfg_model.spin_stop_speed_max = data[nms_pkg::ThreshWidth-1:0];
      nms_pkg::REG_TRACK_STOP_RATE_MAX:
        cfg_model.track_stop_rate_max = data[nms_pkg::ThreshWidth-1:0];
      nms_pkg::REG_IDLE_STOP_SPEED_MAX:
        cfg_model.idle_stop_speed_max = data[nms_pkg::ThreshWidth-1:0];
      nms_pkg::REG_IDLE_STOP_RATE_MAX:
        cfg_model.idle_stop_rate_max = data[nms_pkg::ThreshWidth-1:0];
      nms_pkg::REG_STOP_TIMEOUT_MS:
        cfg_model.stop_timeout_ms = data[nms_pkg::TimeoutWidth-1:0];
      nms_pkg::REG_REVERSE_TIME_MS:
        cfg_model.reverse_time_ms = data[nms_pkg::TimeoutWidth-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Upper bits beyond each register's width are filled at random and must be dropped.
  task automatic load_config(input logic stuck_en,
                             input logic [nms_pkg::ThreshWidth-1:0] spin_speed,
                             input logic [nms_pkg::ThreshWidth-1:0] track_rate,
                             input logic [nms_pkg::ThreshWidth-1:0] idle_speed,
                             input logic [nms_pkg::ThreshWidth-1:0] idle_rate,
                             input logic [nms_pkg::TimeoutWidth-1:0] stop_to,
                             input logic [nms_pkg::TimeoutWidth-1:0] rev_to);
    write_reg(nms_pkg::REG_STUCK_ENABLE, {15'($urandom), stuck_en});
    write_reg(nms_pkg::REG_SPIN_STOP_SPEED_MAX, {1'($urandom), spin_speed});
    write_reg(nms_pkg::REG_TRACK_STOP_RATE_MAX, {1'($urandom), track_rate});
    write_reg(nms_pkg::REG_IDLE_STOP_SPEED_MAX, {1'($urandom), idle_speed});
    write_reg(nms_pkg::REG_IDLE_STOP_RATE_MAX, {1'($urandom), idle_rate});
    write_reg(nms_pkg::REG_STOP_TIMEOUT_MS, stop_to);
    write_reg(nms_pkg::REG_REVERSE_TIME_MS, rev_to);
    write_reg(REG_UNUSED, nms_pkg::CfgDataWidth'($urandom));
  endtask

  function automatic logic [nms_pkg::ThreshWidth-1:0] pick_thresh();
    if (chance(15)) return '0;
    if (chance(15)) return '1;
    return nms_pkg::ThreshWidth'($urandom_range(0, 400));
  endfunction

  function automatic logic [nms_pkg::TimeoutWidth-1:0] pick_timeout();
    if (chance(10)) return '0;
    if (chance(10)) return '1;
    return nms_pkg::TimeoutWidth'($urandom_range(0, 3000));
  endfunction

  task automatic random_config();
    load_config(chance(80), pick_thresh(), pick_thresh(), pick_thresh(), pick_thresh(),
                pick_timeout(), pick_timeout());
  endtask

  task automatic run_phase(input int n_ticks, input int send_pct, input int recv_pct);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
    repeat (n_ticks) tick_q.push_back(random_tick());
    wait_drained();
  endtask

  initial begin
    cfg_model = '{stuck_enable: 1'b1, spin_stop_speed_max: 15'd100,
                  track_stop_rate_max: 15'd100, idle_stop_speed_max: 15'd50,
                  idle_stop_rate_max: 15'd50, stop_timeout_ms: 16'd2000,
                  reverse_time_ms: 16'd1000};
    nav_model = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk through every mode with the reset settings.
    push_tick(F_HAZARD, 16'd0, 16'd0, 32'd0);
    push_tick(F_FRESH, 16'd0, 16'd0, 32'd10);
    push_tick(F_PRESENT | F_STUCK, 16'd0, 16'd0, 32'd20);
    push_tick(F_NONE, 16'd0, 16'd0, 32'd500);
    push_tick(F_NONE, 16'd0, 16'd0, 32'd1100);
    push_tick(F_SAFE, 16'd0, 16'd0, 32'd1110);
    push_tick(F_SPIN, 16'd0, 16'd0, 32'd1120);
    push_tick(F_SPIN | F_PRESENT, 16'd0, 16'sh7FFF, 32'd1130);
    // The most negative rate has magnitude 32768 and never meets a threshold.
    push_tick(F_PRESENT, 16'd0, 16'sh8000, 32'd1140);
    push_tick(F_PRESENT, 16'd0, 16'd99, 32'd1150);
    push_tick(F_PRESENT | F_SPIN | F_URGENT, 16'd0, 16'd0, 32'd1160);
    push_tick(F_PRESENT, 16'sh7FFF, 16'd0, 32'd1170);
    push_tick(F_PRESENT, 16'sh7FFF, 16'd0, 32'd4000);
    push_tick(F_FIXED, 16'd0, 16'd0, 32'd4010);
    push_tick(F_FRESH, 16'sh7FFF, 16'sh7FFF, 32'd4020);
    push_tick(F_PRESENT | F_REACHED | F_FIXED, 16'd0, 16'd0, 32'd4030);
    push_tick(F_FIXED, 16'd10, 16'd10, 32'd4040);
    push_tick(F_SPIN | F_URGENT, 16'd0, 16'd0, 32'd4050);
    push_tick(F_STUCK, 16'd0, 16'd0, 32'd4060);
    // A stamp going backwards looks like a very long reverse.
    push_tick(F_NONE, 16'd0, 16'd0, 32'd0);
    push_tick(F_FRESH, 16'd0, 16'd0, 32'd5);
    push_tick(F_PRESENT | F_REACHED, 16'sh7FFF, 16'sh7FFF, 32'd15);
    push_tick(F_NONE, -16'sd49, 16'sd49, 32'd20);
    push_tick(F_FRESH, 16'd0, 16'd0, 32'hFFFF_FFFF);
    push_tick(F_ALL, 16'sh7FFF, 16'sh8000, 32'd0);
    wait_drained();

    stamp = 32'hFFFF_F000;
    run_phase(150, 0, 0);
    random_config();
    run_phase(150, 47, 0);
    load_config(1'b0, '0, '0, '0, '0, '0, '0);
    run_phase(120, 0, 47);
    load_config(1'b1, '1, '1, '1, '1, '1, '1);
    run_phase(120, 19, 19);
    random_config();
    hold_arm <= 1'b1;
    run_phase(120, 0, 0);
    random_config();
    run_phase(170, 47, 47);
    random_config();
    run_phase(150, 0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mode_expect_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", mode_expect_q.size()));
    end
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
